@@ rtl/core/lsfg_pkg.sv @@
// Shared types and constants for the LED strip frame generator.
package lsfg_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 24;
  localparam int DOTLEN_W  = 6;
  localparam int FUNC_W    = 3;
  localparam int LEVEL_W   = 8;
  localparam int FRAME_W   = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_LEN   = 2'd2;

  // Reset values of the registers
  localparam logic [COLOR_W-1:0]  PRIMARY_RST   = 24'd10;
  localparam logic [COLOR_W-1:0]  SECONDARY_RST = 24'd0;
  localparam logic [DOTLEN_W-1:0] DOT_LEN_RST   = 6'd3;

  // Command function codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_GRADIENT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LIGHT    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DOT      = 3'd3;

  localparam logic [FRAME_W-1:0] START_FRAME = 32'h0000_0000;
  localparam logic [FRAME_W-1:0] DARK_FRAME  = 32'hFF00_0000;
  localparam logic [7:0]         FRAME_MARK  = 8'hFF;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] level;
    logic               side;
  } lsfg_in_t;

  typedef struct packed {
    logic               side_out;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } lsfg_out_t;

  typedef enum logic [1:0] {
    MODE_GRADIENT,
    MODE_LIGHT,
    MODE_DOT
  } mode_t;

  // Classified command passed from front to back
  typedef struct packed {
    mode_t              mode;
    logic [LEVEL_W-1:0] level;   // saturated at the LED count
    logic [LEVEL_W-1:0] start;   // first lit LED in dot mode
    logic               side;
  } cmd_t;

endpackage

@@ rtl/core/lsfg_front.sv @@
// Front end: accepts commands, drops unused modes, saturates level, finds dot start.
module lsfg_front #(
  parameter int LED_COUNT = 32
) (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lsfg_pkg::lsfg_in_t             in_data,
  input  logic [lsfg_pkg::DOTLEN_W-1:0]  dot_length,
  input  logic                           q_full,
  output logic                           q_push,
  output lsfg_pkg::cmd_t                 q_cmd
);
  import lsfg_pkg::*;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LED_COUNT);

  logic               accept;
  logic               func_ok;
  logic [LEVEL_W-1:0] level_sat;
  logic [LEVEL_W-1:0] dot_len_ext;
  mode_t              mode;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    func_ok = 1'b1;
    mode    = MODE_GRADIENT;
    unique case (in_data.func)
      FUNC_GRADIENT: mode = MODE_GRADIENT;
      FUNC_LIGHT:    mode = MODE_LIGHT;
      FUNC_DOT:      mode = MODE_DOT;
      default:       func_ok = 1'b0;
    endcase
  end

  assign level_sat   = (in_data.level > LEVEL_MAX) ? LEVEL_MAX : in_data.level;
  assign dot_len_ext = LEVEL_W'(dot_length);

  // Drop unused modes: the beat is taken but nothing is queued
  assign q_push      = accept & func_ok;
  assign q_cmd.mode  = mode;
  assign q_cmd.level = level_sat;
  assign q_cmd.start = (level_sat > dot_len_ext) ? level_sat - dot_len_ext : '0;
  assign q_cmd.side  = in_data.side;

endmodule

@@ rtl/core/lsfg_cmd_queue.sv @@
// Two-entry command queue between front and back.
module lsfg_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lsfg_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output lsfg_pkg::cmd_t pop_cmd
);
  import lsfg_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_cmd   = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/lsfg_back.sv @@
// Back end: frame sequencer, blend pipeline with constant division, output register.
module lsfg_back #(
  parameter int LED_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lsfg_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  input  logic [lsfg_pkg::COLOR_W-1:0]  primary_color,
  input  logic [lsfg_pkg::COLOR_W-1:0]  secondary_color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lsfg_pkg::lsfg_out_t           out_data
);
  import lsfg_pkg::*;

  localparam int IW  = $clog2(LED_COUNT + 1);        // frame index 0..LED_COUNT
  localparam int NW  = $clog2(255 * LED_COUNT + 1);  // blend numerator
  localparam int KSH = NW;                           // reciprocal scale
  localparam int MW  = KSH + 1;
  localparam int PW  = NW + MW;
  localparam logic [MW-1:0] RECIP    = MW'((2 ** KSH) / LED_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(LED_COUNT);
  localparam logic [NW-1:0] N_NUM    = NW'(LED_COUNT);

  typedef struct packed {
    logic side;
    logic last;
    logic is_start;
    logic lit;
    logic use_blend;
  } flags_t;

  // Sequencer
  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  cmd_t          cmd_r;
  cmd_t          sel_cmd;
  logic          sel_valid;
  logic          adv;
  logic          issue;
  logic [IW-1:0] led;
  logic [LEVEL_W-1:0] led_ext;
  logic          in_range;
  flags_t        flags0;
  logic [NW-1:0] num0 [3];
  logic [7:0]    p_c [3];
  logic [7:0]    s_c [3];

  // Pipeline stages
  logic          v1_r, v2_r;
  flags_t        f1_r, f2_r;
  logic [NW-1:0] num1_r [3];
  logic [NW-1:0] num2_r [3];
  logic [7:0]    q0_r [3];
  logic [PW-1:0] prod [3];
  logic [NW-1:0] rem [3];
  logic [7:0]    qv [3];

  logic          out_valid_r;
  lsfg_out_t     out_data_r, out_data_nxt;

  assign adv       = ~out_valid_r | ~out_stall;
  assign sel_cmd   = busy_r ? cmd_r : q_cmd;
  assign sel_valid = busy_r | q_valid;
  assign issue     = adv & sel_valid;
  assign q_pop     = issue & ~busy_r;

  assign led     = idx_r - IW'(1);
  assign led_ext = LEVEL_W'(led);

  // Red, green, blue components
  assign p_c[0] = primary_color[23:16];
  assign p_c[1] = primary_color[15:8];
  assign p_c[2] = primary_color[7:0];
  assign s_c[0] = secondary_color[23:16];
  assign s_c[1] = secondary_color[15:8];
  assign s_c[2] = secondary_color[7:0];

  always_comb begin
    in_range         = led_ext < sel_cmd.level;
    flags0.side      = sel_cmd.side;
    flags0.is_start  = (idx_r == '0);
    flags0.last      = (idx_r == LAST_IDX);
    flags0.use_blend = (sel_cmd.mode != MODE_LIGHT);
    if (sel_cmd.mode == MODE_DOT) begin
      flags0.lit = in_range & (led_ext >= sel_cmd.start);
    end else begin
      flags0.lit = in_range;
    end
    for (int c = 0; c < 3; c++) begin
      num0[c] = NW'(p_c[c]) * NW'(LAST_IDX - led) + NW'(s_c[c]) * NW'(led);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (issue) begin
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = idx_r + IW'(1);
      end
    end
  end

  // Quotient estimate is the true value or one short; fix with one compare
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PW'(num1_r[c]) * PW'(RECIP);
      rem[c]  = num2_r[c] - NW'(q0_r[c]) * N_NUM;
      qv[c]   = (rem[c] >= N_NUM) ? q0_r[c] + 8'd1 : q0_r[c];
    end
  end

  always_comb begin
    out_data_nxt.side_out = f2_r.side;
    out_data_nxt.last     = f2_r.last;
    if (f2_r.is_start) begin
      out_data_nxt.frame = START_FRAME;
    end else if (!f2_r.lit) begin
      out_data_nxt.frame = DARK_FRAME;
    end else if (f2_r.use_blend) begin
      out_data_nxt.frame = {FRAME_MARK, qv[2], qv[1], qv[0]};
    end else begin
      out_data_nxt.frame = {FRAME_MARK, p_c[2], p_c[1], p_c[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (adv) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (adv) begin
      f1_r       <= flags0;
      f2_r       <= f1_r;
      out_data_r <= out_data_nxt;
      for (int c = 0; c < 3; c++) begin
        num1_r[c] <= num0[c];
        num2_r[c] <= num1_r[c];
        q0_r[c]   <= 8'(prod[c] >> KSH);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/led_strip_frame_generator_core.sv @@
// Top level of the LED strip frame generator: registers, front, queue and back.
//
//   channel  direction  handshake          beat
//   in_      input      in_valid/in_stall  func, level, side (one command)
//   out_     output     out_valid/out_stall side_out, frame, last (one frame)
//   cfg_     input      cfg_valid/cfg_ready register index, write data
//
// A command that produces output yields LED_COUNT + 1 frames (start frame then one
// frame per LED), one frame per cycle while out_ is not stalled. From accept, a
// command passes through the queue, two blend stages and the output register
// before its first frame. Reset is synchronous on rst_n; it clears the queue, the
// sequencer and the valid bits and loads the register reset values. A stall on
// out_ while out_valid is high freezes the whole back pipeline; the queue keeps
// taking commands until it holds two.
module led_strip_frame_generator_core #(
  parameter int LED_COUNT = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lsfg_pkg::lsfg_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lsfg_pkg::lsfg_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsfg_pkg::COLOR_W-1:0]    cfg_data
);
  import lsfg_pkg::*;

  logic [COLOR_W-1:0]  primary_r;
  logic [COLOR_W-1:0]  secondary_r;
  logic [DOTLEN_W-1:0] dot_len_r;

  logic cfg_we;
  logic push, q_full, pop, q_valid;
  cmd_t push_cmd, q_cmd;

  // Always ready: user writes registers only while the block is idle, not enforced
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Hold register values; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r   <= PRIMARY_RST;
      secondary_r <= SECONDARY_RST;
      dot_len_r   <= DOT_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIMARY:   primary_r   <= cfg_data;
        CFG_SECONDARY: secondary_r <= cfg_data;
        CFG_DOT_LEN:   dot_len_r   <= cfg_data[DOTLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify commands and queue the ones that produce frames
  lsfg_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .dot_length (dot_len_r),
    .q_full     (q_full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  lsfg_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // Emit start frame and LED frames, back to back across commands
  lsfg_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (pop),
    .primary_color   (primary_r),
    .secondary_color (secondary_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule
